// File: design/ymbr_pkg.sv
// Shared types, link byte codes and the CRC step for the YMODEM block receiver.
package ymbr_pkg;

    localparam int DEF_SHORT_LEN = 128;
    localparam int DEF_LONG_LEN  = 1024;
    localparam int Q_DEPTH       = 4;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_ESC = 8'h1B;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ACCEPT  = 3'd1;
    localparam logic [2:0] EV_DUP     = 3'd2;
    localparam logic [2:0] EV_NAK     = 3'd3;
    localparam logic [2:0] EV_CANCEL  = 3'd4;
    localparam logic [2:0] EV_DONE    = 3'd5;
    localparam logic [2:0] EV_TIMEOUT = 3'd6;
    localparam logic [2:0] EV_NAKLIM  = 3'd7;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_NAKLIM  = 1'b1;

    // Results of one input item. The second result, when present, is always a reply byte.
    typedef struct packed {
        logic        two;
        logic        s0_txv;
        logic [7:0]  s0_tx;
        logic        s0_dv;
        logic [7:0]  s0_d;
        logic [7:0]  s1_tx;
        logic [2:0]  ev;
        logic [31:0] total;
    } t_desc;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/ymbr_front.sv
// Protocol front end: takes link items, tracks the session and builds result records.
module ymbr_front
    import ymbr_pkg::*;
#(
    parameter int SHORT_LEN = DEF_SHORT_LEN,
    parameter int LONG_LEN  = DEF_LONG_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_push,
    output t_desc       o_desc
);

    localparam int MAX_LEN = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int CNT_W   = $clog2(MAX_LEN);
    localparam logic [CNT_W:0] SHORT_L = (CNT_W + 1)'(SHORT_LEN);
    localparam logic [CNT_W:0] LONG_L  = (CNT_W + 1)'(LONG_LEN);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_SEQ    = 6'b000010,
        PH_NSEQ   = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CRCH   = 6'b010000,
        PH_CRCL   = 6'b100000
    } t_parse;

    typedef enum logic [2:0] {
        SS_FIRST = 3'b001,
        SS_FILE  = 3'b010,
        SS_END   = 3'b100
    } t_sess;

    typedef enum logic [2:0] {
        EN_ONE   = 3'b001,
        EN_TWO   = 3'b010,
        EN_THREE = 3'b100
    } t_end;

    t_parse           r_parse, n_parse;
    t_sess            r_sess, n_sess;
    t_end             r_end, n_end;
    logic [7:0]       r_lgs, n_lgs;
    logic [7:0]       r_this, n_this;
    logic             r_dup, n_dup;
    logic             r_short, n_short;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_crc_rx, n_crc_rx;
    logic [7:0]       r_nak, n_nak;
    logic [31:0]      r_total, n_total;
    logic [15:0]      r_idle, n_idle;
    logic             r_active, n_active;
    logic [15:0]      r_to;
    logic [7:0]       r_nlim;

    // Block completion outcome.
    t_sess       p_sess, p_sess_n;
    t_end        p_end_n;
    logic [1:0]  p_cnt;
    logic [7:0]  p_tx0, p_tx1;
    logic [2:0]  p_ev;
    logic        p_lgs255, p_clear;
    logic [31:0] p_total_n;
    logic [32:0] total_sum;
    logic [CNT_W:0] blk_len, cnt_inc;

    logic        do_cancel, do_nak, do_proc, crc_good;
    logic [2:0]  cancel_ev;
    logic [1:0]  res_cnt;
    logic        res0_txv, res0_dv;
    logic [7:0]  res0_tx, res0_d, res1_tx;
    logic [2:0]  ev;
    logic [15:0] idle_inc, tick_lim, crc_rx_full;

    assign blk_len   = r_short ? SHORT_L : LONG_L;
    assign cnt_inc   = {1'b0, r_cnt} + {{CNT_W{1'b0}}, 1'b1};
    assign total_sum = {1'b0, r_total} + 33'(blk_len);
    // An end of transmission in the header phase moves the session to its ending first.
    assign p_sess    = (r_parse == PH_HEADER) ? SS_END : r_sess;

    always_comb begin
        p_sess_n  = p_sess;
        p_end_n   = r_end;
        p_cnt     = 2'd0;
        p_tx0     = B_ACK;
        p_tx1     = B_C;
        p_ev      = EV_NONE;
        p_lgs255  = 1'b0;
        p_clear   = 1'b0;
        p_total_n = r_total;
        if (r_dup) begin
            p_ev = EV_DUP;
        end else begin
            unique case (p_sess)
                SS_FIRST: begin
                    p_cnt    = 2'd2;
                    p_sess_n = SS_FILE;
                    p_ev     = EV_ACCEPT;
                end
                SS_FILE: begin
                    p_cnt     = 2'd1;
                    p_total_n = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
                    p_ev      = EV_ACCEPT;
                end
                default: begin
                    unique case (r_end)
                        EN_ONE: begin
                            p_cnt   = 2'd1;
                            p_tx0   = B_NAK;
                            p_end_n = EN_TWO;
                        end
                        EN_TWO: begin
                            p_cnt    = 2'd2;
                            p_lgs255 = 1'b1;
                            p_end_n  = EN_THREE;
                        end
                        default: begin
                            p_cnt    = 2'd1;
                            p_clear  = 1'b1;
                            p_sess_n = SS_FIRST;
                            p_end_n  = EN_ONE;
                            p_ev     = EV_DONE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        n_parse  = r_parse;
        n_sess   = r_sess;
        n_end    = r_end;
        n_lgs    = r_lgs;
        n_this   = r_this;
        n_dup    = r_dup;
        n_short  = r_short;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_rx = r_crc_rx;
        n_nak    = r_nak;
        n_total  = r_total;
        n_idle   = r_idle;
        n_active = r_active;
        do_cancel = 1'b0;
        do_nak    = 1'b0;
        do_proc   = 1'b0;
        crc_good  = 1'b0;
        cancel_ev = EV_CANCEL;
        res_cnt   = 2'd0;
        res0_txv  = 1'b0;
        res0_tx   = 8'h00;
        res0_dv   = 1'b0;
        res0_d    = 8'h00;
        res1_tx   = 8'h00;
        ev        = EV_NONE;
        idle_inc    = (r_idle != 16'hFFFF) ? r_idle + 16'd1 : r_idle;
        tick_lim    = (r_to == 16'd0) ? 16'd1 : r_to;
        crc_rx_full = {r_crc_rx[15:8], i_byte};

        if (i_accept) begin
            case (i_kind)
                KIND_START: begin
                    n_parse  = PH_HEADER;
                    n_sess   = SS_FIRST;
                    n_end    = EN_ONE;
                    n_lgs    = 8'hFF;
                    n_this   = 8'h00;
                    n_dup    = 1'b0;
                    n_short  = 1'b0;
                    n_cnt    = '0;
                    n_crc    = 16'h0000;
                    n_crc_rx = 16'h0000;
                    n_nak    = 8'h00;
                    n_total  = 32'h0;
                    n_idle   = 16'h0000;
                    n_active = 1'b1;
                    res_cnt  = 2'd1;
                    res0_txv = 1'b1;
                    res0_tx  = B_C;
                end
                KIND_BYTE: begin
                    if (r_active) begin
                        if (r_nak > r_nlim) begin
                            do_cancel = 1'b1;
                            cancel_ev = EV_NAKLIM;
                        end else begin
                            n_idle = 16'h0000;
                            unique case (r_parse)
                                PH_HEADER: begin
                                    if (i_byte == B_SOH || i_byte == B_STX) begin
                                        n_short = (i_byte == B_SOH);
                                        n_parse = PH_SEQ;
                                        n_cnt   = '0;
                                        n_crc   = 16'h0000;
                                    end else if (i_byte == B_CAN || i_byte == B_ESC) begin
                                        do_cancel = 1'b1;
                                    end else if (i_byte == B_EOT) begin
                                        do_proc = 1'b1;
                                    end
                                end
                                PH_SEQ: begin
                                    if (i_byte == r_lgs ||
                                        i_byte == r_lgs + 8'd1) begin
                                        n_dup   = (i_byte == r_lgs) ? 1'b1 : r_dup;
                                        n_this  = i_byte;
                                        n_parse = PH_NSEQ;
                                    end else begin
                                        do_nak = 1'b1;
                                    end
                                end
                                PH_NSEQ: begin
                                    if (r_this != ~i_byte) begin
                                        do_nak = 1'b1;
                                    end else begin
                                        n_parse = PH_DATA;
                                    end
                                end
                                PH_DATA: begin
                                    res_cnt = 2'd1;
                                    res0_dv = 1'b1;
                                    res0_d  = i_byte;
                                    n_crc   = crc16_step(r_crc, i_byte);
                                    if (cnt_inc >= blk_len) begin
                                        n_parse = PH_CRCH;
                                    end else begin
                                        n_cnt = cnt_inc[CNT_W-1:0];
                                    end
                                end
                                PH_CRCH: begin
                                    n_crc_rx = {i_byte, 8'h00};
                                    n_parse  = PH_CRCL;
                                end
                                default: begin
                                    n_crc_rx = crc_rx_full;
                                    n_parse  = PH_HEADER;
                                    if (r_crc == crc_rx_full) begin
                                        do_proc  = 1'b1;
                                        crc_good = 1'b1;
                                    end else begin
                                        do_nak = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
                KIND_TICK: begin
                    if (r_active) begin
                        n_idle = idle_inc;
                        if (idle_inc >= tick_lim) begin
                            do_cancel = 1'b1;
                            cancel_ev = EV_TIMEOUT;
                        end else if (r_nak > r_nlim) begin
                            do_cancel = 1'b1;
                            cancel_ev = EV_NAKLIM;
                        end else if (r_sess == SS_FIRST) begin
                            res_cnt  = 2'd1;
                            res0_txv = 1'b1;
                            res0_tx  = B_C;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_cancel) begin
            res_cnt  = 2'd2;
            res0_txv = 1'b1;
            res0_tx  = B_CAN;
            res1_tx  = B_CAN;
            n_end    = EN_ONE;
            n_sess   = SS_FIRST;
            n_parse  = PH_HEADER;
            n_active = 1'b0;
            n_cnt    = '0;
            ev       = cancel_ev;
        end

        if (do_nak) begin
            res_cnt  = 2'd1;
            res0_txv = 1'b1;
            res0_tx  = B_NAK;
            n_parse  = PH_HEADER;
            n_cnt    = '0;
            n_nak    = (r_nak != 8'hFF) ? r_nak + 8'd1 : r_nak;
            n_dup    = 1'b0;
            ev       = EV_NAK;
        end

        if (do_proc) begin
            n_sess  = p_sess_n;
            n_end   = p_end_n;
            n_total = p_total_n;
            if (p_lgs255) begin
                n_lgs = 8'hFF;
            end
            if (p_clear) begin
                n_parse  = PH_HEADER;
                n_active = 1'b0;
                n_cnt    = '0;
            end
            res_cnt  = p_cnt;
            res0_txv = (p_cnt != 2'd0);
            res0_tx  = (p_cnt != 2'd0) ? p_tx0 : 8'h00;
            res1_tx  = (p_cnt == 2'd2) ? p_tx1 : 8'h00;
            ev       = p_ev;
            if (crc_good) begin
                n_lgs = r_this;
                n_dup = 1'b0;
                n_cnt = '0;
            end
        end

        // An event with no reply still needs one result to carry it.
        if (ev != EV_NONE && res_cnt == 2'd0) begin
            res_cnt = 2'd1;
        end
    end

    assign o_push        = (res_cnt != 2'd0);
    assign o_desc.two    = (res_cnt == 2'd2);
    assign o_desc.s0_txv = res0_txv;
    assign o_desc.s0_tx  = res0_tx;
    assign o_desc.s0_dv  = res0_dv;
    assign o_desc.s0_d   = res0_d;
    assign o_desc.s1_tx  = res1_tx;
    assign o_desc.ev     = ev;
    assign o_desc.total  = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse  <= PH_HEADER;
            r_sess   <= SS_FIRST;
            r_end    <= EN_ONE;
            r_lgs    <= 8'hFF;
            r_this   <= 8'h00;
            r_dup    <= 1'b0;
            r_short  <= 1'b0;
            r_cnt    <= '0;
            r_crc    <= 16'h0000;
            r_crc_rx <= 16'h0000;
            r_nak    <= 8'h00;
            r_total  <= 32'h0;
            r_idle   <= 16'h0000;
            r_active <= 1'b0;
            r_to     <= 16'd1000;
            r_nlim   <= 8'd10;
        end else begin
            r_parse  <= n_parse;
            r_sess   <= n_sess;
            r_end    <= n_end;
            r_lgs    <= n_lgs;
            r_this   <= n_this;
            r_dup    <= n_dup;
            r_short  <= n_short;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
            r_nak    <= n_nak;
            r_total  <= n_total;
            r_idle   <= n_idle;
            r_active <= n_active;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TIMEOUT) begin
                    r_to <= i_cfg_wdata;
                end else begin
                    r_nlim <= i_cfg_wdata[7:0];
                end
            end
        end
    end

`ifndef SYNTH
    // The session only closes through an item whose record carries a closing event.
    a_close_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) |-> $past(o_push && (o_desc.ev == EV_CANCEL ||
            o_desc.ev == EV_DONE || o_desc.ev == EV_TIMEOUT || o_desc.ev == EV_NAKLIM)))
        else $error("session closed without a closing event");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_kind == KIND_START) |=>
            (r_active && r_nak == 8'h00 && r_total == 32'h0 && r_parse == PH_HEADER))
        else $error("start item did not open a clean session");
`endif

endmodule

// File: design/ymbr_fifo.sv
// Short queue of result records between the front end and the output stage.
module ymbr_fifo
    import ymbr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_desc            r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("record queue written while full");
`endif

endmodule

// File: design/ymbr_back.sv
// Output stage: turns each record into one or two result transfers on the master stream.
module ymbr_back
    import ymbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_desc       i_head,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [55:0] o_tdata,
    output logic        o_tlast
);

    t_desc r_desc;
    logic  r_valid;
    logic  r_sel;
    logic  fire, done_desc, load;

    assign fire      = r_valid && i_tready;
    assign done_desc = fire && (r_sel || !r_desc.two);
    assign load      = !r_valid || done_desc;
    assign o_pop     = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_sel   <= 1'b0;
        end else if (fire) begin
            r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_head;
        end
    end

    // Fields from the lowest bit: tx_valid, tx_byte, data_valid, data_byte, event, total.
    always_comb begin
        o_tvalid = r_valid;
        if (r_sel) begin
            o_tdata = {3'b000, r_desc.total, r_desc.ev, 8'h00, 1'b0, r_desc.s1_tx, 1'b1};
            o_tlast = 1'b1;
        end else begin
            o_tdata = {3'b000, r_desc.total, (r_desc.two ? EV_NONE : r_desc.ev),
                       r_desc.s0_d, r_desc.s0_dv, r_desc.s0_tx, r_desc.s0_txv};
            o_tlast = !r_desc.two;
        end
    end

`ifndef SYNTH
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && i_tready && !o_tlast) |=> (o_tvalid && o_tlast))
        else $error("second result of a pair missing");
`endif

endmodule

// File: design/ymodem_block_receiver_core.sv
// Top level of the YMODEM block receiver with CRC-16 check.
//
// Input stream (s_axis): one link event per transfer. tuser carries the kind
// (received byte, time tick, start session); tdata carries the received byte.
// Output stream (m_axis): one to two result transfers per input event; tlast
// marks the final result of an event. Events that cause no result produce no
// transfer. The configuration port writes the timeout and NAK limit; the user
// must write them only while idle, as the block itself does not enforce it.
//
// The front end decodes an event and updates the session in the cycle it is
// accepted, so a new event can be taken every cycle while the queue is not
// full. Its record goes into a four-entry queue, from which the output stage
// loads it into its own register before showing the first result. Sustained
// rate is one event per cycle for single-result events while the master side
// accepts every transfer; an event that returns two replies holds the single
// output port for two transfers. When the master side stalls, the queue fills
// and s_axis_tready drops when it holds four records. Reset clears the queue
// and the session; the block stays inactive until a start event.
module ymodem_block_receiver_core
    import ymbr_pkg::*;
#(
    parameter int SHORT_LEN = DEF_SHORT_LEN,
    parameter int LONG_LEN  = DEF_LONG_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // byte_value
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_valid, tx_byte, data_valid, data_byte, event_res, total_bytes, zero fill
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic  accept, push, full, pop, empty;
    t_desc push_desc, head_desc;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ymbr_front #(
        .SHORT_LEN (SHORT_LEN),
        .LONG_LEN  (LONG_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    ymbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_desc)
    );

    ymbr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_desc),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule
